### sv/bmmd_pkg.sv
`default_nettype none

package bmmd_pkg;

  // Store geometry
  localparam int unsigned ROM_BANKS  = 8;
  localparam int unsigned WRAM_BANKS = 8;
  localparam int unsigned VRAM_BANKS = 2;

  localparam int unsigned ROM_PAGE  = 16384;
  localparam int unsigned VRAM_PAGE = 8192;
  localparam int unsigned WRAM_PAGE = 4096;
  localparam int unsigned CART_SIZE = 8192;
  localparam int unsigned OAM_SIZE  = 160;
  localparam int unsigned HIGH_SIZE = 256;

  localparam int unsigned ROM_DEPTH  = ROM_BANKS * ROM_PAGE;
  localparam int unsigned VRAM_DEPTH = VRAM_BANKS * VRAM_PAGE;
  localparam int unsigned WRAM_DEPTH = WRAM_BANKS * WRAM_PAGE;

  localparam int unsigned ROM_AW  = $clog2(ROM_DEPTH);
  localparam int unsigned VRAM_AW = $clog2(VRAM_DEPTH);
  localparam int unsigned WRAM_AW = $clog2(WRAM_DEPTH);
  localparam int unsigned CART_AW = $clog2(CART_SIZE);
  localparam int unsigned OAM_AW  = $clog2(OAM_SIZE);
  localparam int unsigned HIGH_AW = $clog2(HIGH_SIZE);

  localparam int unsigned ROM_BW  = ROM_AW - $clog2(ROM_PAGE);
  localparam int unsigned WRAM_BW = WRAM_AW - $clog2(WRAM_PAGE);

  localparam int unsigned IDX_W0 = (ROM_AW > WRAM_AW) ? ROM_AW : WRAM_AW;
  localparam int unsigned IDX_W  = (IDX_W0 > VRAM_AW) ? IDX_W0 : VRAM_AW;

  // Bus map boundaries
  localparam logic [15:0] ADDR_ROMX  = 16'h4000;
  localparam logic [15:0] ADDR_VRAM  = 16'h8000;
  localparam logic [15:0] ADDR_CART  = 16'hA000;
  localparam logic [15:0] ADDR_WRAM0 = 16'hC000;
  localparam logic [15:0] ADDR_WRAMX = 16'hD000;
  localparam logic [15:0] ADDR_ECHO  = 16'hE000;
  localparam logic [15:0] ADDR_OAM   = 16'hFE00;
  localparam logic [15:0] ADDR_GAP   = 16'hFEA0;
  localparam logic [15:0] ADDR_HIGH  = 16'hFF00;
  localparam logic [15:0] ECHO_SHIFT = 16'h2000;

  // Request kinds
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_LOAD  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_ROM_BANK  = 2'd0;
  localparam logic [1:0] CFG_VRAM_BANK = 2'd1;
  localparam logic [1:0] CFG_WRAM_BANK = 2'd2;

  // Request queue
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  typedef enum logic [2:0] {
    SEL_NONE,
    SEL_ROM,
    SEL_VRAM,
    SEL_CART,
    SEL_WRAM,
    SEL_OAM,
    SEL_HIGH
  } sel_e;

  typedef struct packed {
    logic             is_read;
    sel_e             sel;
    logic [IDX_W-1:0] idx;
    logic [7:0]       data;
  } req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // Fold a 3-bit bank number into 0..n-1 by repeated subtraction.
  function automatic logic [7:0] wrap_bank(input logic [2:0] b, input int unsigned n);
    logic [8:0] v;
    v = {6'd0, b};
    for (int i = 0; i < 4; i++) begin
      if (v >= 9'(n)) begin
        v = v - 9'(n);
      end
    end
    return v[7:0];
  endfunction

endpackage

`default_nettype wire

### sv/bmmd_ram.sv
`default_nettype none

module bmmd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### sv/bmmd_front.sv
`default_nettype none

module bmmd_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [1:0]    cfg_idx_i,
  input  wire logic [2:0]    cfg_data_i,
  input  wire logic          fire_i,
  input  wire logic [1:0]    kind_i,
  input  wire logic [15:0]   addr_i,
  input  wire logic [7:0]    wdata_i,
  input  wire logic [16:0]   offset_i,
  output logic               push_o,
  output bmmd_pkg::req_t     req_o
);

  logic [2:0] rom_bank_q, rom_bank_d;
  logic       vram_bank_q, vram_bank_d;
  logic [2:0] wram_bank_q, wram_bank_d;

  always_comb begin
    rom_bank_d  = rom_bank_q;
    vram_bank_d = vram_bank_q;
    wram_bank_d = wram_bank_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bmmd_pkg::CFG_ROM_BANK:  rom_bank_d  = cfg_data_i;
        bmmd_pkg::CFG_VRAM_BANK: vram_bank_d = cfg_data_i[0];
        bmmd_pkg::CFG_WRAM_BANK: wram_bank_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_bank_q  <= 3'd1;
      vram_bank_q <= 1'b0;
      wram_bank_q <= 3'd1;
    end else begin
      rom_bank_q  <= rom_bank_d;
      vram_bank_q <= vram_bank_d;
      wram_bank_q <= wram_bank_d;
    end
  end

  logic [15:0]                   ea;
  logic [7:0]                    rom_sel_bank;
  logic [7:0]                    load_bank;
  logic [7:0]                    wram_sel_bank;
  logic                          vram_sel_bank;
  bmmd_pkg::sel_e                bus_sel;
  logic [bmmd_pkg::IDX_W-1:0]    bus_idx;
  logic [bmmd_pkg::ROM_AW-1:0]   load_idx;

  always_comb begin
    // Echo space mirrors the work RAM window below it
    if (addr_i >= bmmd_pkg::ADDR_ECHO && addr_i < bmmd_pkg::ADDR_OAM) begin
      ea = addr_i - bmmd_pkg::ECHO_SHIFT;
    end else begin
      ea = addr_i;
    end

    rom_sel_bank  = bmmd_pkg::wrap_bank(rom_bank_q, bmmd_pkg::ROM_BANKS);
    wram_sel_bank = bmmd_pkg::wrap_bank(wram_bank_q, bmmd_pkg::WRAM_BANKS);
    load_bank     = bmmd_pkg::wrap_bank(offset_i[16:14], bmmd_pkg::ROM_BANKS);
    vram_sel_bank = (bmmd_pkg::VRAM_BANKS > 1) ? vram_bank_q : 1'b0;
    load_idx      = {load_bank[bmmd_pkg::ROM_BW-1:0], offset_i[13:0]};

    priority if (ea < bmmd_pkg::ADDR_ROMX) begin
      bus_sel = bmmd_pkg::SEL_ROM;
      bus_idx = bmmd_pkg::IDX_W'(ea[13:0]);
    end else if (ea < bmmd_pkg::ADDR_VRAM) begin
      bus_sel = bmmd_pkg::SEL_ROM;
      bus_idx = bmmd_pkg::IDX_W'({rom_sel_bank[bmmd_pkg::ROM_BW-1:0], ea[13:0]});
    end else if (ea < bmmd_pkg::ADDR_CART) begin
      bus_sel = bmmd_pkg::SEL_VRAM;
      bus_idx = bmmd_pkg::IDX_W'(bmmd_pkg::VRAM_AW'({vram_sel_bank, ea[12:0]}));
    end else if (ea < bmmd_pkg::ADDR_WRAM0) begin
      bus_sel = bmmd_pkg::SEL_CART;
      bus_idx = bmmd_pkg::IDX_W'(ea[12:0]);
    end else if (ea < bmmd_pkg::ADDR_WRAMX) begin
      bus_sel = bmmd_pkg::SEL_WRAM;
      bus_idx = bmmd_pkg::IDX_W'(ea[11:0]);
    end else if (ea < bmmd_pkg::ADDR_ECHO) begin
      bus_sel = bmmd_pkg::SEL_WRAM;
      bus_idx = bmmd_pkg::IDX_W'({wram_sel_bank[bmmd_pkg::WRAM_BW-1:0], ea[11:0]});
    end else if (ea >= bmmd_pkg::ADDR_OAM && ea < bmmd_pkg::ADDR_GAP) begin
      bus_sel = bmmd_pkg::SEL_OAM;
      bus_idx = bmmd_pkg::IDX_W'(ea[7:0]);
    end else if (ea >= bmmd_pkg::ADDR_HIGH) begin
      bus_sel = bmmd_pkg::SEL_HIGH;
      bus_idx = bmmd_pkg::IDX_W'(ea[7:0]);
    end else begin
      bus_sel = bmmd_pkg::SEL_NONE;
      bus_idx = '0;
    end

    req_o.data    = wdata_i;
    req_o.is_read = 1'b0;
    req_o.sel     = bus_sel;
    req_o.idx     = bus_idx;
    push_o        = 1'b0;
    unique case (kind_i)
      bmmd_pkg::KIND_READ: begin
        req_o.is_read = 1'b1;
        push_o        = fire_i;
      end
      bmmd_pkg::KIND_WRITE: begin
        // drop writes that land on ROM or unmapped space
        push_o = fire_i && bus_sel != bmmd_pkg::SEL_ROM && bus_sel != bmmd_pkg::SEL_NONE;
      end
      bmmd_pkg::KIND_LOAD: begin
        req_o.sel = bmmd_pkg::SEL_ROM;
        req_o.idx = bmmd_pkg::IDX_W'(load_idx);
        push_o    = fire_i;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### sv/bmmd_queue.sv
`default_nettype none

module bmmd_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire bmmd_pkg::req_t req_i,
  input  wire logic           pop_i,
  output bmmd_pkg::req_t      head_o,
  output bmmd_pkg::qstat_t    stat_o
);

  bmmd_pkg::req_t            entry_q [bmmd_pkg::QDEPTH];
  logic [bmmd_pkg::QAW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [bmmd_pkg::QAW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [bmmd_pkg::QAW:0]    count_q, count_d;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + (bmmd_pkg::QAW + 1)'(push_i) - (bmmd_pkg::QAW + 1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= req_i;
    end
  end

  assign head_o       = entry_q[rd_ptr_q];
  assign stat_o.full  = (count_q == (bmmd_pkg::QAW + 1)'(bmmd_pkg::QDEPTH));
  assign stat_o.empty = (count_q == '0);

endmodule

`default_nettype wire

### sv/bmmd_back.sv
`default_nettype none

module bmmd_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire bmmd_pkg::req_t head_i,
  input  wire logic           empty_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [7:0]          out_data_o
);

  logic           pend_q, pend_d;
  bmmd_pkg::sel_e pend_sel_q;
  logic           out_valid_q, out_valid_d;
  logic [7:0]     out_data_q, out_data_d;
  logic           wr_en;

  logic [7:0] rom_rd, vram_rd, cart_rd, wram_rd, oam_rd, high_rd;

  // Reads need the single output slot to be free when their data lands
  assign pop_o = !empty_i && (!head_i.is_read || (!pend_q && (!out_valid_q || out_ready_i)));
  assign wr_en = pop_o && !head_i.is_read;

  bmmd_ram #(.WIDTH(8), .DEPTH(bmmd_pkg::ROM_DEPTH)) u_rom (
    .clk_i   (clk_i),
    .we_i    (wr_en && head_i.sel == bmmd_pkg::SEL_ROM),
    .addr_i  (head_i.idx[bmmd_pkg::ROM_AW-1:0]),
    .wdata_i (head_i.data),
    .rdata_o (rom_rd)
  );

  bmmd_ram #(.WIDTH(8), .DEPTH(bmmd_pkg::VRAM_DEPTH)) u_vram (
    .clk_i   (clk_i),
    .we_i    (wr_en && head_i.sel == bmmd_pkg::SEL_VRAM),
    .addr_i  (head_i.idx[bmmd_pkg::VRAM_AW-1:0]),
    .wdata_i (head_i.data),
    .rdata_o (vram_rd)
  );

  bmmd_ram #(.WIDTH(8), .DEPTH(bmmd_pkg::CART_SIZE)) u_cart (
    .clk_i   (clk_i),
    .we_i    (wr_en && head_i.sel == bmmd_pkg::SEL_CART),
    .addr_i  (head_i.idx[bmmd_pkg::CART_AW-1:0]),
    .wdata_i (head_i.data),
    .rdata_o (cart_rd)
  );

  bmmd_ram #(.WIDTH(8), .DEPTH(bmmd_pkg::WRAM_DEPTH)) u_wram (
    .clk_i   (clk_i),
    .we_i    (wr_en && head_i.sel == bmmd_pkg::SEL_WRAM),
    .addr_i  (head_i.idx[bmmd_pkg::WRAM_AW-1:0]),
    .wdata_i (head_i.data),
    .rdata_o (wram_rd)
  );

  bmmd_ram #(.WIDTH(8), .DEPTH(bmmd_pkg::OAM_SIZE)) u_oam (
    .clk_i   (clk_i),
    .we_i    (wr_en && head_i.sel == bmmd_pkg::SEL_OAM),
    .addr_i  (head_i.idx[bmmd_pkg::OAM_AW-1:0]),
    .wdata_i (head_i.data),
    .rdata_o (oam_rd)
  );

  bmmd_ram #(.WIDTH(8), .DEPTH(bmmd_pkg::HIGH_SIZE)) u_high (
    .clk_i   (clk_i),
    .we_i    (wr_en && head_i.sel == bmmd_pkg::SEL_HIGH),
    .addr_i  (head_i.idx[bmmd_pkg::HIGH_AW-1:0]),
    .wdata_i (head_i.data),
    .rdata_o (high_rd)
  );

  always_comb begin
    pend_d      = pop_o && head_i.is_read;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q;
    if (pend_q) begin
      out_valid_d = 1'b1;
      unique case (pend_sel_q)
        bmmd_pkg::SEL_ROM:  out_data_d = rom_rd;
        bmmd_pkg::SEL_VRAM: out_data_d = vram_rd;
        bmmd_pkg::SEL_CART: out_data_d = cart_rd;
        bmmd_pkg::SEL_WRAM: out_data_d = wram_rd;
        bmmd_pkg::SEL_OAM:  out_data_d = oam_rd;
        bmmd_pkg::SEL_HIGH: out_data_d = high_rd;
        default:            out_data_d = 8'd0;
      endcase
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_sel_q <= head_i.sel;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

### sv/banked_memory_map_decoder_top.sv
`default_nettype none

// Banked memory map decoder: each slave-side request is a bus read (tuser 0), a bus
// write (tuser 1) or one ROM image byte load (tuser 2); tuser 3 is dropped. Reads
// return exactly one byte on the master side (0 for unmapped space); writes and loads
// return nothing, and writes to ROM or unmapped space are dropped. Map: ROM 0000-7FFF
// (4000-7FFF shows rom_bank), video RAM 8000-9FFF (vram_bank), cart RAM A000-BFFF,
// work RAM C000-CFFF bank 0 and D000-DFFF (wram_bank), echo E000-FDFF of C000-DDFF,
// sprite table FE00-FE9F, high page FF00-FFFF. Bank numbers beyond the stores wrap.
// Change banks only while idle. The front decodes a request in the cycle it is
// accepted and pushes it into a four-entry queue; the back drains the queue into
// single-port RAMs with a registered read port. Writes and loads retire one per
// cycle unless a read ahead of them is held at the queue head. A read passes the
// RAM read register and then the output register, and the back pops no new read
// while one is still in its RAM read. Stores power up undefined and need no
// clearing pass: read only what was written or loaded.
module banked_memory_map_decoder_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [2:0]  cfg_data_i,

  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // address[15:0], wdata[23:16], rom_offset[40:24]
  input  wire logic [1:0]  s_axis_tuser,   // kind[1:0]

  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata    // read_data[7:0]
);

  logic              fire;
  logic              push;
  logic              pop;
  bmmd_pkg::req_t    req;
  bmmd_pkg::req_t    head;
  bmmd_pkg::qstat_t  qstat;

  // Accept whenever the queue has room; dropped requests consume no slot
  assign s_axis_tready = !qstat.full;
  assign fire          = s_axis_tvalid && s_axis_tready;

  bmmd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .fire_i     (fire),
    .kind_i     (s_axis_tuser),
    .addr_i     (s_axis_tdata[15:0]),
    .wdata_i    (s_axis_tdata[23:16]),
    .offset_i   (s_axis_tdata[40:24]),
    .push_o     (push),
    .req_o      (req)
  );

  // Decouple decode from RAM access
  bmmd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .req_i  (req),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (qstat)
  );

  bmmd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (qstat.empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !qstat.full)
    else $error("request pushed into a full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !qstat.empty)
    else $error("request popped from an empty queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(qstat.full && qstat.empty))
    else $error("queue reports full and empty at once");
`endif

endmodule

`default_nettype wire

### verif/banked_memory_map_decoder_top_tb.sv
`default_nettype none

module banked_memory_map_decoder_top_tb;
  import bmmd_pkg::*;

  // Kind code that the block must drop without a response
  localparam logic [1:0] KIND_NONE = 2'd3;

  // Flat byte image of every store, one region after the other
  localparam int ROM_BASE  = 0;
  localparam int VRAM_BASE = ROM_BASE + ROM_DEPTH;
  localparam int CART_BASE = VRAM_BASE + VRAM_DEPTH;
  localparam int WRAM_BASE = CART_BASE + CART_SIZE;
  localparam int OAM_BASE  = WRAM_BASE + WRAM_DEPTH;
  localparam int HIGH_BASE = OAM_BASE + OAM_SIZE;
  localparam int CELLS     = HIGH_BASE + HIGH_SIZE;

  localparam int RANDOM_REQS   = 1200;
  localparam int PHASE_REQS    = 150;
  localparam int SETTLE_CYCLES = 12;   // queue drain plus read pipe, with margin
  localparam int DRAIN_CYCLES  = 20;
  localparam int WATCHDOG_MAX  = 3000;
  localparam int HOT_MAX       = 512;

  typedef enum logic [1:0] {
    ACT_REQ,
    ACT_CFG,
    ACT_HOLD
  } step_e;

  typedef struct {
    step_e       act;
    logic [1:0]  kind;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic [16:0] off;
    logic [1:0]  cfg_idx;
    logic [2:0]  cfg_val;
  } step_t;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i   = 1'b0;
  logic [1:0]  cfg_idx_i  = '0;
  logic [2:0]  cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;  // address[15:0], wdata[23:16], rom_offset[40:24]
  logic [1:0]  s_axis_tuser  = '0;  // kind[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // read_data[7:0]

  banked_memory_map_decoder_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // Requests and register writes waiting for the driver, in program order
  step_t pending_reqs[$];
  // Read bytes the block still owes, oldest first
  logic [7:0] rd_expect[$];

  // Predicted store contents and bank registers, advanced at acceptance
  logic [7:0] mem_image [CELLS];
  logic [2:0] live_rom_bank  = 3'd1;
  logic       live_vram_bank = 1'b0;
  logic [2:0] live_wram_bank = 3'd1;

  // Generation-time view: which cells hold data, and the banks at that point
  bit          gen_written [CELLS];
  logic [15:0] hot_addrs[$];
  logic [2:0]  gen_rom_bank  = 3'd1;
  logic        gen_vram_bank = 1'b0;
  logic [2:0]  gen_wram_bank = 3'd1;

  int fail_count   = 0;
  int quiet_cycles = 0;
  int watchdog     = 0;
  bit req_taken    = 1'b0;

  // Map a bus address onto the flat image; -1 for the unmapped gap
  function automatic int bus_cell(input logic [15:0] a, input logic [2:0] rb,
                                  input logic vb, input logic [2:0] wb);
    logic [15:0] m;
    m = a;
    // echo folds onto C000-DDFF
    if (a >= ADDR_ECHO && a < ADDR_OAM) m = a - ECHO_SHIFT;
    if (m < ADDR_ROMX)  return ROM_BASE + int'(m);
    if (m < ADDR_VRAM)  return ROM_BASE + int'({rb, m[13:0]});
    if (m < ADDR_CART)  return VRAM_BASE + int'({vb, m[12:0]});
    if (m < ADDR_WRAM0) return CART_BASE + int'(m[12:0]);
    if (m < ADDR_WRAMX) return WRAM_BASE + int'(m[11:0]);
    if (m < ADDR_ECHO)  return WRAM_BASE + int'({wb, m[11:0]});
    if (m < ADDR_GAP)   return OAM_BASE + int'(m - ADDR_OAM);
    if (m < ADDR_HIGH)  return -1;
    return HIGH_BASE + int'(m[7:0]);
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  // Queue one request and track what it leaves readable
  task automatic add_req(input logic [1:0] kind, input logic [15:0] addr,
                         input logic [7:0] wdata, input logic [16:0] off);
    step_t s;
    int    c;
    s = '{ACT_REQ, kind, addr, wdata, off, 2'd0, 3'd0};
    pending_reqs.push_back(s);
    if (kind == KIND_WRITE && addr >= ADDR_VRAM) begin
      c = bus_cell(addr, gen_rom_bank, gen_vram_bank, gen_wram_bank);
      if (c >= 0) begin
        gen_written[c] = 1'b1;
        hot_addrs.push_back(addr);
      end
    end else if (kind == KIND_LOAD) begin
      gen_written[ROM_BASE + int'(off)] = 1'b1;
      // remember the bus address if the byte is visible right now
      if (off < 17'h04000) hot_addrs.push_back({2'b00, off[13:0]});
      else if (off[16:14] == gen_rom_bank) hot_addrs.push_back({2'b01, off[13:0]});
    end
    if (hot_addrs.size() > HOT_MAX) void'(hot_addrs.pop_front());
  endtask

  task automatic add_cfg(input logic [1:0] idx, input logic [2:0] val);
    step_t s;
    s = '{ACT_CFG, KIND_NONE, 16'd0, 8'd0, 17'd0, idx, val};
    pending_reqs.push_back(s);
    case (idx)
      CFG_ROM_BANK:  gen_rom_bank  = val;
      CFG_VRAM_BANK: gen_vram_bank = val[0];
      CFG_WRAM_BANK: gen_wram_bank = val;
      default: ;
    endcase
  endtask

  task automatic add_hold();
    step_t s;
    s = '{ACT_HOLD, KIND_NONE, 16'd0, 8'd0, 17'd0, 2'd0, 3'd0};
    pending_reqs.push_back(s);
  endtask

  // Read address that only touches written cells or the unmapped gap
  function automatic logic [15:0] pick_read_addr();
    logic [15:0] a;
    int          c;
    for (int i = 0; i < 30; i++) begin
      if (hot_addrs.size() != 0 && $urandom_range(9) < 8)
        a = hot_addrs[$urandom_range(hot_addrs.size() - 1)];
      else
        a = 16'($urandom_range(16'hFFFF));
      c = bus_cell(a, gen_rom_bank, gen_vram_bank, gen_wram_bank);
      if (c < 0 || gen_written[c]) return a;
    end
    return ADDR_GAP + 16'($urandom_range(16'h5F));
  endfunction

  function automatic logic [2:0] pick_bank();
    int r;
    r = $urandom_range(3);
    if (r == 0) return 3'd0;
    if (r == 1) return 3'd7;
    return 3'($urandom_range(7));
  endfunction

  task automatic build_directed();
    // ROM image edges, bank 0 and the last byte of the image
    add_req(KIND_LOAD, 16'h0000, 8'h00, 17'h00000);
    add_req(KIND_LOAD, 16'h0000, 8'hFF, 17'h03FFF);
    add_req(KIND_LOAD, 16'h0000, 8'h5A, 17'h04000);
    add_req(KIND_LOAD, 16'hFFFF, 8'hA5, 17'h1FFFF);
    // write into ROM space and a dropped kind must both leave ROM alone
    add_req(KIND_WRITE, 16'h0000, 8'h33, 17'h1FFFF);
    add_req(KIND_NONE, 16'h0000, 8'hEE, 17'h00000);
    add_req(KIND_READ, 16'h0000, 8'h00, 17'h00000);
    add_req(KIND_READ, 16'h3FFF, 8'h00, 17'h00000);
    add_req(KIND_READ, 16'h4000, 8'h00, 17'h00000);
    // region edges, echo on both ends, and the unmapped gap
    add_req(KIND_WRITE, 16'h8000, 8'hFF, 17'h00000);
    add_req(KIND_WRITE, 16'h9FFF, 8'h01, 17'h00000);
    add_req(KIND_WRITE, 16'hA000, 8'h80, 17'h00000);
    add_req(KIND_WRITE, 16'hBFFF, 8'h7F, 17'h00000);
    add_req(KIND_WRITE, 16'hE000, 8'h99, 17'h00000);
    add_req(KIND_WRITE, 16'hFDFF, 8'hC3, 17'h00000);
    add_req(KIND_WRITE, 16'hFE9F, 8'h44, 17'h00000);
    add_req(KIND_WRITE, 16'hFEA0, 8'h12, 17'h00000);
    add_req(KIND_WRITE, 16'hFFFF, 8'h77, 17'h00000);
    add_req(KIND_READ, 16'hC000, 8'h00, 17'h00000);
    add_req(KIND_READ, 16'hDDFF, 8'h00, 17'h00000);
    add_req(KIND_READ, 16'hFEA0, 8'h00, 17'h00000);
    add_req(KIND_READ, 16'hFFFF, 8'h00, 17'h00000);
    add_req(KIND_READ, 16'h8000, 8'h00, 17'h00000);
    // ROM bank zero shows bank 0 up high; bank 7 reaches the image end
    add_cfg(CFG_ROM_BANK, 3'd0);
    add_req(KIND_READ, 16'h4000, 8'h00, 17'h00000);
    add_cfg(CFG_ROM_BANK, 3'd7);
    add_req(KIND_READ, 16'h7FFF, 8'h00, 17'h00000);
    // work bank zero shows bank 0 at D000
    add_cfg(CFG_WRAM_BANK, 3'd0);
    add_req(KIND_READ, 16'hD000, 8'h00, 17'h00000);
    add_cfg(CFG_WRAM_BANK, 3'd7);
    add_cfg(CFG_VRAM_BANK, 3'd1);
  endtask

  task automatic build_random();
    logic [15:0] a;
    logic [16:0] o;
    logic [15:0] bases [7];
    int          r;
    bases = '{16'h8000, 16'hA000, 16'hC000, 16'hD000, 16'hE000, 16'hFE00, 16'hFF00};
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % PHASE_REQS == 0) begin
        add_cfg(CFG_ROM_BANK, pick_bank());
        add_cfg(CFG_VRAM_BANK, 3'($urandom_range(7)));
        add_cfg(CFG_WRAM_BANK, pick_bank());
      end
      if ($urandom_range(99) == 0) add_hold();
      r = $urandom_range(99);
      if (r < 40) begin
        add_req(KIND_READ, pick_read_addr(), 8'($urandom_range(255)),
                17'($urandom_range(17'h1FFFF)));
      end else if (r < 72) begin
        // half anywhere, half clustered so reads and overwrites hit
        if ($urandom_range(1)) a = 16'($urandom_range(16'hFFFF));
        else a = bases[$urandom_range(6)] + 16'($urandom_range(31));
        add_req(KIND_WRITE, a, 8'($urandom_range(255)), 17'($urandom_range(17'h1FFFF)));
      end else if (r < 95) begin
        if ($urandom_range(9) < 4) begin
          o = 17'($urandom_range(17'h1FFFF));
        end else begin
          o[13:0]  = $urandom_range(1) ? 14'($urandom_range(63)) : 14'($urandom_range(14'h3FFF));
          o[16:14] = $urandom_range(1) ? 3'd0 : gen_rom_bank;
        end
        add_req(KIND_LOAD, 16'($urandom_range(16'hFFFF)), 8'($urandom_range(255)), o);
      end else begin
        add_req(KIND_NONE, 16'($urandom_range(16'hFFFF)), 8'($urandom_range(255)),
                17'($urandom_range(17'h1FFFF)));
      end
    end
  endtask

  // Apply one accepted request to the predicted stores
  task automatic predict_request(input logic [1:0] kind, input logic [15:0] addr,
                                 input logic [7:0] wdata, input logic [16:0] off);
    int c;
    c = bus_cell(addr, live_rom_bank, live_vram_bank, live_wram_bank);
    case (kind)
      KIND_READ:  rd_expect.push_back((c < 0) ? 8'h00 : mem_image[c]);
      KIND_WRITE: if (c >= 0 && addr >= ADDR_VRAM) mem_image[c] = wdata;
      KIND_LOAD:  mem_image[ROM_BASE + int'(off)] = wdata;
      default: ;
    endcase
  endtask

  // Driver: present the next pending step at the falling edge
  int send_gap  = 0;
  bit send_calm = 1'b0;
  int cyc_count = 0;

  always @(negedge clk_i) begin
    logic        nv;
    logic [47:0] nd;
    logic [1:0]  nu;
    logic        nwe;
    logic [1:0]  ni;
    logic [2:0]  nc;
    step_t       s;
    nv  = s_axis_tvalid;
    nd  = s_axis_tdata;
    nu  = s_axis_tuser;
    nwe = 1'b0;
    ni  = cfg_idx_i;
    nc  = cfg_data_i;
    if (rst_ni) begin
      cyc_count++;
      if (cyc_count % 256 == 0) send_calm = ($urandom_range(3) == 0);
      // drop the request once it has been taken
      if (nv && req_taken) nv = 1'b0;
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_reqs.size() != 0) begin
          s = pending_reqs[0];
          case (s.act)
            ACT_REQ: begin
              nv = 1'b1;
              nu = s.kind;
              nd = {7'd0, s.off, s.wdata, s.addr};
              void'(pending_reqs.pop_front());
              send_gap = send_calm ? 0 : pick_gap();
            end
            ACT_CFG: begin
              // banks change only once the block has gone quiet
              if (quiet_cycles >= SETTLE_CYCLES) begin
                nwe = 1'b1;
                ni  = s.cfg_idx;
                nc  = s.cfg_val;
                void'(pending_reqs.pop_front());
              end
            end
            default: begin
              // hold until every owed read byte is back
              if (quiet_cycles >= 1) void'(pending_reqs.pop_front());
            end
          endcase
        end
      end
    end
    s_axis_tvalid <= nv;
    s_axis_tdata  <= nd;
    s_axis_tuser  <= nu;
    cfg_we_i      <= nwe;
    cfg_idx_i     <= ni;
    cfg_data_i    <= nc;
  end

  // Receiver: stall the master side at random, with calm stretches
  int recv_stall = 0;
  bit recv_calm  = 1'b0;

  always @(negedge clk_i) begin
    logic rdy;
    rdy = 1'b1;
    if (cyc_count % 256 == 128) recv_calm = ($urandom_range(3) == 0);
    if (!rst_ni) begin
      rdy = 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall--;
      rdy = 1'b0;
    end else if (!recv_calm && $urandom_range(99) < 30) begin
      recv_stall = pick_gap();
    end
    m_axis_tready <= rdy;
  end

  // Monitor: sample both sides at the rising edge
  always @(posedge clk_i) begin
    logic s_fire;
    logic m_fire;
    s_fire = rst_ni && s_axis_tvalid && s_axis_tready;
    m_fire = rst_ni && m_axis_tvalid && m_axis_tready;
    req_taken <= s_fire;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ROM_BANK:  live_rom_bank  = cfg_data_i;
          CFG_VRAM_BANK: live_vram_bank = cfg_data_i[0];
          CFG_WRAM_BANK: live_wram_bank = cfg_data_i;
          default: ;
        endcase
      end
      if (m_fire) begin
        if (rd_expect.size() == 0) begin
          $error("read_data with no read waiting: expected none actual %02h", m_axis_tdata);
          fail_count++;
        end else begin
          if (m_axis_tdata !== rd_expect[0]) begin
            $error("read_data mismatch: expected %02h actual %02h", rd_expect[0],
                   m_axis_tdata);
            fail_count++;
          end
          void'(rd_expect.pop_front());
        end
      end
      if (s_fire)
        predict_request(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[23:16],
                        s_axis_tdata[40:24]);
      if (s_fire || m_fire || s_axis_tvalid || rd_expect.size() != 0) quiet_cycles = 0;
      else quiet_cycles++;
      // watchdog: too long without any request, result or register write
      if (s_fire || m_fire || cfg_we_i) watchdog = 0;
      else watchdog++;
      if (watchdog >= WATCHDOG_MAX) begin
        $display("banked_memory_map_decoder_top_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    build_directed();
    build_random();
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    // wait for the stimulus to drain, then for every owed byte
    while (pending_reqs.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (rd_expect.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (rd_expect.size() != 0) begin
      $error("read_data missing: expected %0d more results", rd_expect.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("banked_memory_map_decoder_top_tb OK");
    end else begin
      $display("banked_memory_map_decoder_top_tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
